@@ rtl/moving_average_filter_top_defines.svh @@
// Assertion macros used by maf_datapath.
`ifndef MOVING_AVERAGE_FILTER_TOP_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MAF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("moving average filter: same-cycle check failed");
`define MAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("moving average filter: next-cycle check failed");
`else
`define MAF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MAF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/maf_pkg.sv @@
package maf_pkg;

   localparam int MAX_WINDOW = 1024;
   localparam int SAMPLE_W   = 24;
   localparam int WLEN_W     = 11;
   localparam int ADDR_W     = $clog2(MAX_WINDOW);
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W      = SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int STEP_W     = $clog2(SUM_W + 1);
   localparam int CMP_W      = (WLEN_W > CNT_W) ? WLEN_W : CNT_W;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic rd;
      logic update;
      logic div_start;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } stat_type;

   // zero means a window of one; anything above the store depth saturates
   function automatic logic [CNT_W-1:0] active_window(input logic [WLEN_W-1:0] wlen);
      logic [CMP_W-1:0] wx;
      wx = CMP_W'(wlen);
      if (wx == '0) begin
         wx = CMP_W'(1);
      end else if (wx > CMP_W'(MAX_WINDOW)) begin
         wx = CMP_W'(MAX_WINDOW);
      end
      return CNT_W'(wx);
   endfunction

endpackage

@@ rtl/moving_average_filter_top.sv @@
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | req_sample  (24b signed Q1.23)
// rsp     | out       | rsp_valid, rsp_stall | rsp_average (24b signed Q1.23)
// csr     | in/out    | APB write/read       | window_length at byte address 0
//
// Steps per word, one word at a time: accept, store read, sum update,
// divide setup, the one-bit-a-cycle restoring divider, then the handoff
// to the output register.
// Synchronous active-high reset; window length resets to 1, fill count and sum cleared.
// A held result does not block the next word; the next one waits only if the
// previous result is still stalled when its divide finishes.
module moving_average_filter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [maf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [maf_pkg::SAMPLE_W-1:0] rsp_average,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [maf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [maf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [maf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   maf_pkg::cmd_type  cmd;
   maf_pkg::stat_type stat;

   maf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   maf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_average (rsp_average),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

endmodule

@@ rtl/maf_ram.sv @@
module maf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/maf_ctrl.sv @@
module maf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  maf_pkg::stat_type stat,
   output maf_pkg::cmd_type  cmd
);

   maf_pkg::state_type state_ff;
   maf_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= maf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         maf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = maf_pkg::ST_READ;
            end
         end
         maf_pkg::ST_READ:   state_in = maf_pkg::ST_UPDATE;
         maf_pkg::ST_UPDATE: state_in = maf_pkg::ST_START;
         maf_pkg::ST_START:  state_in = maf_pkg::ST_DIVIDE;
         maf_pkg::ST_DIVIDE: begin
            if (stat.div_done) begin
               state_in = maf_pkg::ST_OUTPUT;
            end
         end
         maf_pkg::ST_OUTPUT: begin
            if (stat.out_free) begin
               state_in = maf_pkg::ST_IDLE;
            end
         end
         default: state_in = maf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         maf_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         maf_pkg::ST_READ:   cmd.rd = 1'b1;
         maf_pkg::ST_UPDATE: cmd.update = 1'b1;
         maf_pkg::ST_START:  cmd.div_start = 1'b1;
         maf_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
         maf_pkg::ST_OUTPUT: cmd.load_out = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

@@ rtl/maf_datapath.sv @@
`include "moving_average_filter_top_defines.svh"

module maf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  maf_pkg::cmd_type                    cmd,
   output maf_pkg::stat_type                   stat,
   input  logic signed [maf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [maf_pkg::SAMPLE_W-1:0] rsp_average,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [maf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [maf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [maf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic [maf_pkg::WLEN_W-1:0]          wlen_ff;
   logic [maf_pkg::CNT_W-1:0]           win;
   logic                                csr_wr;

   logic [maf_pkg::ADDR_W-1:0]          wp_ff;
   logic [maf_pkg::ADDR_W-1:0]          wp_in;
   logic [maf_pkg::CNT_W-1:0]           wp_next;
   logic [maf_pkg::CNT_W-1:0]           fill_ff;
   logic [maf_pkg::CNT_W-1:0]           fill_in;
   logic signed [maf_pkg::SUM_W-1:0]    sum_ff;
   logic signed [maf_pkg::SUM_W-1:0]    sum_in;
   logic signed [maf_pkg::SAMPLE_W-1:0] sample_ff;
   logic [maf_pkg::SAMPLE_W-1:0]        old_word;
   logic                                full;

   logic [maf_pkg::SUM_W-1:0]           dvd_ff;
   logic [maf_pkg::SUM_W-1:0]           dvd_in;
   logic [maf_pkg::CNT_W-1:0]           dsr_ff;
   logic [maf_pkg::CNT_W-1:0]           rem_ff;
   logic [maf_pkg::CNT_W-1:0]           rem_in;
   logic [maf_pkg::CNT_W:0]             shifted;
   logic [maf_pkg::CNT_W:0]             trial;
   logic                                neg_ff;
   logic [maf_pkg::STEP_W-1:0]          step_ff;

   logic                                rsp_valid_ff;
   logic signed [maf_pkg::SAMPLE_W-1:0] rsp_average_ff;
   logic [maf_pkg::SAMPLE_W-1:0]        quot;

   // config register
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & ~csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? '0 : maf_pkg::CSR_DATA_W'(wlen_ff);
   assign win        = maf_pkg::active_window(wlen_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= maf_pkg::WLEN_W'(1);
      end else if (csr_wr) begin
         wlen_ff <= csr_pwdata[maf_pkg::WLEN_W-1:0];
      end
   end

   maf_ram #(
      .WIDTH (maf_pkg::SAMPLE_W),
      .DEPTH (maf_pkg::MAX_WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.rd),
      .rd_addr (wp_ff),
      .rd_data (old_word)
   );

   // ring position, fill count and running sum
   assign full    = (fill_ff == win);
   assign wp_next = maf_pkg::CNT_W'(wp_ff) + maf_pkg::CNT_W'(1);
   assign wp_in   = (wp_next >= win) ? '0 : wp_next[maf_pkg::ADDR_W-1:0];
   assign fill_in = full ? fill_ff : fill_ff + maf_pkg::CNT_W'(1);
   assign sum_in  = sum_ff + maf_pkg::SUM_W'(sample_ff)
                  - (full ? maf_pkg::SUM_W'($signed(old_word)) : '0);

   always_ff @(posedge clock) begin
      if (reset || csr_wr) begin
         wp_ff   <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else if (cmd.update) begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample;
      end
   end

   // restoring divide of |sum| by the fill count, one quotient bit a cycle
   assign shifted = {rem_ff, dvd_ff[maf_pkg::SUM_W-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign rem_in  = trial[maf_pkg::CNT_W] ? shifted[maf_pkg::CNT_W-1:0]
                                          : trial[maf_pkg::CNT_W-1:0];
   assign dvd_in  = {dvd_ff[maf_pkg::SUM_W-2:0], ~trial[maf_pkg::CNT_W]};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff  <= sum_ff[maf_pkg::SUM_W-1];
         dvd_ff  <= sum_ff[maf_pkg::SUM_W-1] ? maf_pkg::SUM_W'(-sum_ff)
                                             : maf_pkg::SUM_W'(sum_ff);
         dsr_ff  <= fill_ff;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= dvd_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + maf_pkg::STEP_W'(1);
      end
   end

   assign stat.div_done = (step_ff == maf_pkg::STEP_W'(maf_pkg::SUM_W - 1));

   // output word register
   assign quot          = dvd_ff[maf_pkg::SAMPLE_W-1:0];
   assign stat.out_free = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_average_ff <= neg_ff ? -quot : quot;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   `MAF_ASSERT_IMPLY(a_fill_in_window, clock, reset, 1'b1, fill_ff <= win)
   `MAF_ASSERT_IMPLY(a_pos_in_window, clock, reset, 1'b1, maf_pkg::CNT_W'(wp_ff) < win)
   `MAF_ASSERT_NEXT(a_divisor_nonzero, clock, reset, cmd.update && !csr_wr, fill_ff != '0)

endmodule
